[src/sdre_pkg.sv]
// sdre_pkg: shared types and constants of the sparse ReLU network evaluator.
// Used by sdre_fpu and by the top level sparse_dag_relu_net_evaluator.
// No dependencies.
package sdre_pkg;

	// default sizes of the network memories
	localparam int MAX_NODES_DEF   = 128;
	localparam int MAX_CONN_DEF    = 512;
	localparam int MAX_OUTPUTS_DEF = 16;
	localparam int RESULT_LIMIT    = 16;

	// item field widths
	localparam int KIND_W  = 3;
	localparam int SLOT_W  = 9;
	localparam int START_W = 10;
	localparam int REF_W   = 7;
	localparam int WORD_W  = 32;
	localparam int POS_W   = 4;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam int IN_NODES_W = 8;
	localparam int TOT_NODES_W = 8;
	localparam int OUT_ENT_W  = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_INPUT_NODES    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_NODES    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_ENTRIES = 2'd2;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_OFFSET = 3'd0;
	localparam logic [KIND_W-1:0] KIND_BIAS   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_CONN   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_OMAP   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_INPUT  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_EVAL   = 3'd5;

	// binary32 constants
	localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;
	localparam logic [31:0] FP_ZERO = 32'h0000_0000;

	// floating point unit operation
	typedef enum logic [1:0] {
		FP_MUL = 2'b01,
		FP_ADD = 2'b10
	} fp_op_t;

	// request from the sequencer to the floating point unit
	typedef struct packed {
		logic   start;
		fp_op_t op;
	} fp_req_t;

endpackage

[src/sparse_dag_relu_net_evaluator.sv]
// sparse_dag_relu_net_evaluator: top level, sequencer and network memories.
// Depends on sdre_pkg, sdre_ram and sdre_fpu.
//
// channel  direction  handshake             payload
// in       in         in_valid / in_ready   kind, slot, start_count, node_ref, data_word
// out      out        out_valid / out_ready out_word, out_position, status, last
// cfg      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// Load items are written as they are accepted. An evaluate item checks the offsets
// of every node, the source of every connection and every output entry, then
// evaluates each non-input node with a multiply and an add on the shared unit per
// connection, and last sends each result, held while out_ready is low.
// in_ready is low for the whole evaluation. Reset clears the control state and
// the configuration registers; the memories hold undefined data until written.
module sparse_dag_relu_net_evaluator #(
	parameter int MAX_NODES       = sdre_pkg::MAX_NODES_DEF,
	parameter int MAX_CONNECTIONS = sdre_pkg::MAX_CONN_DEF,
	parameter int MAX_OUTPUTS     = sdre_pkg::MAX_OUTPUTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [sdre_pkg::KIND_W-1:0]      kind,
	input  logic [sdre_pkg::SLOT_W-1:0]      slot,
	input  logic [sdre_pkg::START_W-1:0]     start_count,
	input  logic [sdre_pkg::REF_W-1:0]       node_ref,
	input  logic [sdre_pkg::WORD_W-1:0]      data_word,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [sdre_pkg::WORD_W-1:0]      out_word,
	output logic [sdre_pkg::POS_W-1:0]       out_position,
	output logic                             status,
	output logic                             last,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sdre_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sdre_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int NW   = $clog2(MAX_NODES + 1);
	localparam int NAW  = $clog2(MAX_NODES);
	localparam int OFAW = $clog2(MAX_NODES + 1);
	localparam int CAW  = (MAX_CONNECTIONS > 1) ? $clog2(MAX_CONNECTIONS) : 1;
	localparam int MAW  = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
	localparam int CW   = sdre_pkg::REF_W + sdre_pkg::WORD_W;

	typedef enum logic [22:0] {
		S_IDLE   = 23'h000001,
		S_C_OFF0 = 23'h000002,
		S_C_BEG  = 23'h000004,
		S_C_NODE = 23'h000008,
		S_C_END  = 23'h000010,
		S_C_SRC  = 23'h000020,
		S_C_SCHK = 23'h000040,
		S_C_OMAP = 23'h000080,
		S_C_OCHK = 23'h000100,
		S_E_NODE = 23'h000200,
		S_E_BEG  = 23'h000400,
		S_E_END  = 23'h000800,
		S_E_CONN = 23'h001000,
		S_E_SRC  = 23'h002000,
		S_E_VAL  = 23'h004000,
		S_E_MUL  = 23'h008000,
		S_E_ADD  = 23'h010000,
		S_E_WR   = 23'h020000,
		S_O_MAP  = 23'h040000,
		S_O_NV   = 23'h080000,
		S_O_LOAD = 23'h100000,
		S_O_WAIT = 23'h200000,
		S_ERR    = 23'h400000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [sdre_pkg::IN_NODES_W-1:0]  in_nodes_q;
	logic [sdre_pkg::TOT_NODES_W-1:0] tot_nodes_q;
	logic [sdre_pkg::OUT_ENT_W-1:0]   out_ent_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_nodes_q  <= '0;
			tot_nodes_q <= '0;
			out_ent_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sdre_pkg::CFG_INPUT_NODES:    in_nodes_q  <= cfg_data;
				sdre_pkg::CFG_TOTAL_NODES:    tot_nodes_q <= cfg_data;
				sdre_pkg::CFG_OUTPUT_ENTRIES: out_ent_q   <= cfg_data[sdre_pkg::OUT_ENT_W-1:0];
				default: ;
			endcase
		end
	end

	// counters and working registers
	logic [NW-1:0]                 node_q;
	logic [sdre_pkg::START_W-1:0]  idx_q, begin_q, end_q;
	logic [sdre_pkg::WORD_W-1:0]   sum_q;
	logic                          out_valid_q, out_status_q, out_last_q;
	logic [sdre_pkg::WORD_W-1:0]   out_word_q;
	logic [sdre_pkg::POS_W-1:0]    out_pos_q;

	// memory read data
	logic [sdre_pkg::START_W-1:0]  off_rd;
	logic [sdre_pkg::WORD_W-1:0]   bias_rd, nv_rd;
	logic [CW-1:0]                 conn_rd;
	logic [sdre_pkg::REF_W-1:0]    map_rd, conn_src;
	logic [sdre_pkg::WORD_W-1:0]   conn_wt;

	assign conn_src = conn_rd[CW-1:sdre_pkg::WORD_W];
	assign conn_wt  = conn_rd[sdre_pkg::WORD_W-1:0];

	// widened views for compares and address slices
	logic [31:0] node_w, nodep1_w, idx_w, in_w, tot_w, oe_w, slot_w;
	logic [31:0] off_w, begin_w, src_w, map_w;

	assign node_w   = 32'(node_q);
	assign nodep1_w = node_w + 32'd1;
	assign idx_w    = 32'(idx_q);
	assign in_w     = 32'(in_nodes_q);
	assign tot_w    = 32'(tot_nodes_q);
	assign oe_w     = 32'(out_ent_q);
	assign slot_w   = 32'(slot);
	assign off_w    = 32'(off_rd);
	assign begin_w  = 32'(begin_q);
	assign src_w    = 32'(conn_src);
	assign map_w    = 32'(map_rd);

	logic accept, node_done, idx_done, regs_bad, off_bad, src_bad, map_bad, is_last;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign node_done = (node_w == tot_w);
	assign idx_done  = (idx_q == end_q);
	assign is_last   = ((idx_w + 32'd1) == oe_w);

	// checks on the configuration alone
	assign regs_bad = (tot_w == 32'd0) || (tot_w > 32'(MAX_NODES)) || (in_w > tot_w)
	               || (oe_w == 32'd0) || (oe_w > 32'(MAX_OUTPUTS))
	               || (oe_w > 32'(sdre_pkg::RESULT_LIMIT));
	// per-node offset checks, then per-connection and per-output checks
	assign off_bad = (off_w < begin_w) || ((node_w < in_w) && (off_w != begin_w))
	              || (off_w > 32'(MAX_CONNECTIONS));
	assign src_bad = (src_w >= node_w);
	assign map_bad = (map_w >= tot_w);

	// ReLU: anything not strictly positive, NaN included, becomes +0
	logic                        sum_pos;
	logic [sdre_pkg::WORD_W-1:0] relu_w;

	assign sum_pos = !sum_q[31] && (sum_q[30:0] != 31'd0)
	              && !((sum_q[30:23] == 8'hFF) && (sum_q[22:0] != 23'd0));
	assign relu_w  = sum_pos ? sum_q : sdre_pkg::FP_ZERO;

	// shared floating point unit
	sdre_pkg::fp_req_t           fp_req;
	logic [sdre_pkg::WORD_W-1:0] fp_a, fp_b, fp_res;
	logic                        fp_done;

	always_comb begin
		fp_req.start = (state_q == S_E_VAL) || ((state_q == S_E_MUL) && fp_done);
		fp_req.op    = (state_q == S_E_VAL) ? sdre_pkg::FP_MUL : sdre_pkg::FP_ADD;
		fp_a         = (state_q == S_E_VAL) ? conn_wt : sum_q;
		fp_b         = (state_q == S_E_VAL) ? nv_rd : fp_res;
	end

	sdre_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fp_req),
		.a      (fp_a),
		.b      (fp_b),
		.done   (fp_done),
		.result (fp_res)
	);

	// memory control
	logic               off_we, off_re, bias_we, bias_re, conn_we, conn_re;
	logic               map_we, map_re, nv_we, nv_re;
	logic [OFAW-1:0]    off_raddr;
	logic [NAW-1:0]     nv_waddr, nv_raddr;
	logic [sdre_pkg::WORD_W-1:0] nv_wdata;

	always_comb begin
		off_we  = accept && (kind == sdre_pkg::KIND_OFFSET) && (slot_w < 32'(MAX_NODES + 1));
		bias_we = accept && (kind == sdre_pkg::KIND_BIAS) && (slot_w < 32'(MAX_NODES));
		conn_we = accept && (kind == sdre_pkg::KIND_CONN) && (slot_w < 32'(MAX_CONNECTIONS));
		map_we  = accept && (kind == sdre_pkg::KIND_OMAP) && (slot_w < 32'(MAX_OUTPUTS));
		nv_we   = (accept && (kind == sdre_pkg::KIND_INPUT) && (slot_w < 32'(MAX_NODES)))
		       || (state_q == S_E_WR);
		nv_waddr = (state_q == S_E_WR) ? node_w[NAW-1:0] : slot_w[NAW-1:0];
		nv_wdata = (state_q == S_E_WR) ? relu_w : data_word;

		off_re = (state_q == S_C_OFF0) || (state_q == S_E_BEG)
		      || (((state_q == S_C_NODE) || (state_q == S_E_NODE)) && !node_done);
		off_raddr = ((state_q == S_C_NODE) || (state_q == S_E_BEG)) ? nodep1_w[OFAW-1:0]
		          : ((state_q == S_C_OFF0) ? '0 : node_w[OFAW-1:0]);
		bias_re = (state_q == S_E_NODE) && !node_done;
		conn_re = ((state_q == S_C_SRC) || (state_q == S_E_CONN)) && !idx_done;
		map_re  = ((state_q == S_C_OMAP) || (state_q == S_O_MAP)) && (idx_w != oe_w);
		nv_re   = (state_q == S_E_SRC) || (state_q == S_O_NV);
		nv_raddr = (state_q == S_O_NV) ? map_w[NAW-1:0] : src_w[NAW-1:0];
	end

	sdre_ram #(.WIDTH(sdre_pkg::START_W), .DEPTH(MAX_NODES + 1)) u_off_ram (
		.clk(clk), .we(off_we), .waddr(slot_w[OFAW-1:0]), .wdata(start_count),
		.re(off_re), .raddr(off_raddr), .rdata(off_rd)
	);

	sdre_ram #(.WIDTH(sdre_pkg::WORD_W), .DEPTH(MAX_NODES)) u_bias_ram (
		.clk(clk), .we(bias_we), .waddr(slot_w[NAW-1:0]), .wdata(data_word),
		.re(bias_re), .raddr(node_w[NAW-1:0]), .rdata(bias_rd)
	);

	sdre_ram #(.WIDTH(CW), .DEPTH(MAX_CONNECTIONS)) u_conn_ram (
		.clk(clk), .we(conn_we), .waddr(slot_w[CAW-1:0]), .wdata({node_ref, data_word}),
		.re(conn_re), .raddr(idx_w[CAW-1:0]), .rdata(conn_rd)
	);

	sdre_ram #(.WIDTH(sdre_pkg::REF_W), .DEPTH(MAX_OUTPUTS)) u_map_ram (
		.clk(clk), .we(map_we), .waddr(slot_w[MAW-1:0]), .wdata(node_ref),
		.re(map_re), .raddr(idx_w[MAW-1:0]), .rdata(map_rd)
	);

	sdre_ram #(.WIDTH(sdre_pkg::WORD_W), .DEPTH(MAX_NODES)) u_nv_ram (
		.clk(clk), .we(nv_we), .waddr(nv_waddr), .wdata(nv_wdata),
		.re(nv_re), .raddr(nv_raddr), .rdata(nv_rd)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			node_q       <= '0;
			idx_q        <= '0;
			begin_q      <= '0;
			end_q        <= '0;
			sum_q        <= '0;
			out_valid_q  <= 1'b0;
			out_word_q   <= '0;
			out_pos_q    <= '0;
			out_status_q <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && (kind == sdre_pkg::KIND_EVAL)) begin
						node_q  <= '0;
						state_q <= regs_bad ? S_ERR : S_C_OFF0;
					end
				end
				S_C_OFF0: state_q <= S_C_BEG;
				S_C_BEG: begin
					begin_q <= off_rd;
					state_q <= S_C_NODE;
				end
				S_C_NODE: begin
					if (node_done) begin
						idx_q   <= '0;
						state_q <= S_C_OMAP;
					end else begin
						state_q <= S_C_END;
					end
				end
				S_C_END: begin
					end_q   <= off_rd;
					idx_q   <= begin_q;
					state_q <= off_bad ? S_ERR : S_C_SRC;
				end
				S_C_SRC: begin
					if (idx_done) begin
						begin_q <= end_q;
						node_q  <= node_q + 1'b1;
						state_q <= S_C_NODE;
					end else begin
						state_q <= S_C_SCHK;
					end
				end
				S_C_SCHK: begin
					idx_q   <= idx_q + 1'b1;
					state_q <= src_bad ? S_ERR : S_C_SRC;
				end
				S_C_OMAP: begin
					if (idx_w == oe_w) begin
						node_q  <= NW'(in_nodes_q);
						state_q <= S_E_NODE;
					end else begin
						state_q <= S_C_OCHK;
					end
				end
				S_C_OCHK: begin
					idx_q   <= idx_q + 1'b1;
					state_q <= map_bad ? S_ERR : S_C_OMAP;
				end
				S_E_NODE: begin
					if (node_done) begin
						idx_q   <= '0;
						state_q <= S_O_MAP;
					end else begin
						state_q <= S_E_BEG;
					end
				end
				S_E_BEG: begin
					begin_q <= off_rd;
					sum_q   <= bias_rd;
					state_q <= S_E_END;
				end
				S_E_END: begin
					end_q   <= off_rd;
					idx_q   <= begin_q;
					state_q <= S_E_CONN;
				end
				S_E_CONN: state_q <= idx_done ? S_E_WR : S_E_SRC;
				S_E_SRC:  state_q <= S_E_VAL;
				S_E_VAL:  state_q <= S_E_MUL;
				S_E_MUL: begin
					if (fp_done) begin
						state_q <= S_E_ADD;
					end
				end
				S_E_ADD: begin
					if (fp_done) begin
						sum_q   <= fp_res;
						idx_q   <= idx_q + 1'b1;
						state_q <= S_E_CONN;
					end
				end
				S_E_WR: begin
					node_q  <= node_q + 1'b1;
					state_q <= S_E_NODE;
				end
				S_O_MAP: state_q <= S_O_NV;
				S_O_NV:  state_q <= S_O_LOAD;
				S_O_LOAD: begin
					out_valid_q  <= 1'b1;
					out_word_q   <= nv_rd;
					out_pos_q    <= idx_q[sdre_pkg::POS_W-1:0];
					out_status_q <= 1'b0;
					out_last_q   <= is_last;
					state_q      <= S_O_WAIT;
				end
				S_ERR: begin
					out_valid_q  <= 1'b1;
					out_word_q   <= sdre_pkg::FP_ZERO;
					out_pos_q    <= '0;
					out_status_q <= 1'b1;
					out_last_q   <= 1'b1;
					state_q      <= S_O_WAIT;
				end
				S_O_WAIT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_O_MAP;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign out_word     = out_word_q;
	assign out_position = out_pos_q;
	assign status       = out_status_q;
	assign last         = out_last_q;

`ifndef NO_ASSERTIONS
	// no new item while a result is still on offer
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready while a result is pending");

	// the final result of an evaluation frees the block
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last) |=> in_ready)
		else $error("block not idle after final result");

	// a malformed network gives a single result
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> last)
		else $error("error result not marked last");

	// evaluate item makes the block busy
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (kind == sdre_pkg::KIND_EVAL)) |=> !in_ready)
		else $error("input ready right after evaluate item");
`endif

endmodule

[src/sdre_ram.sv]
// sdre_ram: generic single write port, single read port RAM with registered read.
// No dependencies.
module sdre_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/sdre_fpu.sv]
// sdre_fpu: binary32 multiply or add with round to nearest even, as a pipeline.
// Depends on sdre_pkg (fp_req_t, fp_op_t, FP_QNAN).
// Both operations share the leading one search, normalising shift and rounding.
module sdre_fpu (
	input  logic              clk,
	input  logic              arst_n,
	input  sdre_pkg::fp_req_t req,
	input  logic [31:0]       a,
	input  logic [31:0]       b,
	output logic              done,
	output logic [31:0]       result
);

	// ---------------- stage 1: unpack, multiply or align and add
	logic [7:0]  ea, eb, eaa, ebb;
	logic [23:0] siga, sigb;
	logic        sa, sb;
	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

	assign sa = a[31];
	assign sb = b[31];
	assign ea = a[30:23];
	assign eb = b[30:23];
	assign a_nan  = (ea == 8'hFF) && (a[22:0] != 23'd0);
	assign b_nan  = (eb == 8'hFF) && (b[22:0] != 23'd0);
	assign a_inf  = (ea == 8'hFF) && (a[22:0] == 23'd0);
	assign b_inf  = (eb == 8'hFF) && (b[22:0] == 23'd0);
	assign a_zero = (ea == 8'h00) && (a[22:0] == 23'd0);
	assign b_zero = (eb == 8'h00) && (b[22:0] == 23'd0);
	assign siga = {(ea != 8'h00), a[22:0]};
	assign sigb = {(eb != 8'h00), b[22:0]};
	assign eaa  = (ea == 8'h00) ? 8'd1 : ea;
	assign ebb  = (eb == 8'h00) ? 8'd1 : eb;

	// multiply path
	logic [47:0]       mul_m;
	logic signed [10:0] mul_e;
	logic              mul_nan, mul_inf;

	assign mul_m   = siga * sigb;
	assign mul_e   = $signed({3'b000, eaa}) + $signed({3'b000, ebb}) - 11'sd150;
	assign mul_nan = a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
	assign mul_inf = a_inf || b_inf;

	// add path: larger magnitude first, smaller aligned with guard, round, sticky
	logic              a_big, mag_eq, s_big;
	logic [7:0]        e_big, e_sm, d;
	logic [4:0]        d_c;
	logic [23:0]       sig_big, sig_sm;
	logic [26:0]       big27, sm27, shifted, lost, small27;
	logic [27:0]       add_m;
	logic signed [10:0] add_e;
	logic              add_s, add_nan;

	assign a_big   = {eaa, siga} >= {ebb, sigb};
	assign mag_eq  = {eaa, siga} == {ebb, sigb};
	assign e_big   = a_big ? eaa : ebb;
	assign e_sm    = a_big ? ebb : eaa;
	assign sig_big = a_big ? siga : sigb;
	assign sig_sm  = a_big ? sigb : siga;
	assign s_big   = a_big ? sa : sb;
	assign d       = e_big - e_sm;
	assign d_c     = (d > 8'd27) ? 5'd27 : d[4:0];
	assign big27   = {sig_big, 3'b000};
	assign sm27    = {sig_sm, 3'b000};
	assign shifted = sm27 >> d_c;
	assign lost    = sm27 & ~(27'h7FF_FFFF << d_c);
	assign small27 = shifted | {26'd0, |lost};
	assign add_m   = (sa == sb) ? ({1'b0, big27} + {1'b0, small27})
	                            : ({1'b0, big27} - {1'b0, small27});
	assign add_e   = $signed({3'b000, e_big}) - 11'sd3;
	// exact cancellation gives +0
	assign add_s   = ((sa != sb) && mag_eq) ? 1'b0 : s_big;
	assign add_nan = a_nan || b_nan || (a_inf && b_inf && (sa != sb));

	logic              v_s1, s_s1, spec_s1;
	logic [31:0]       spec_word_s1;
	logic signed [10:0] e_s1;
	logic [47:0]       m_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= req.start;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			if (req.op == sdre_pkg::FP_MUL) begin
				m_s1    <= mul_m;
				e_s1    <= mul_e;
				s_s1    <= sa ^ sb;
				spec_s1 <= mul_nan || mul_inf;
				spec_word_s1 <= mul_nan ? sdre_pkg::FP_QNAN : {sa ^ sb, 8'hFF, 23'd0};
			end else begin
				m_s1    <= 48'(add_m);
				e_s1    <= add_e;
				s_s1    <= add_s;
				spec_s1 <= add_nan || a_inf || b_inf;
				spec_word_s1 <= add_nan ? sdre_pkg::FP_QNAN
				              : (a_inf ? {sa, 8'hFF, 23'd0} : {sb, 8'hFF, 23'd0});
			end
		end
	end

	// ---------------- stage 2: leading one and shift amount
	logic [5:0]         p;
	logic signed [10:0] k_a, k_b, k;

	always_comb begin
		p = 6'd0;
		for (int i = 0; i < 48; i++) begin
			if (m_s1[i]) begin
				p = 6'(i);
			end
		end
	end

	// normal results put the leading one at bit 23; tiny ones stop at exponent 1
	assign k_a = $signed({5'd0, p}) - 11'sd23;
	assign k_b = 11'sd1 - e_s1;
	assign k   = (k_a > k_b) ? k_a : k_b;

	logic              v_s2, s_s2, spec_s2, zero_s2;
	logic [31:0]       spec_word_s2;
	logic signed [10:0] k_s2, be_s2;
	logic [47:0]       m_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			m_s2         <= m_s1;
			k_s2         <= k;
			be_s2        <= e_s1 + k;
			s_s2         <= s_s1;
			zero_s2      <= (m_s1 == 48'd0);
			spec_s2      <= spec_s1;
			spec_word_s2 <= spec_word_s1;
		end
	end

	// ---------------- stage 3: shift, round, pack
	logic [6:0]         sh;
	logic [73:0]        ext, q, gvec, mask;
	logic [23:0]        sig, sig_f;
	logic [24:0]        sig25;
	logic               g, st, inc;
	logic signed [10:0] be_f;
	logic [31:0]        packed_w;

	assign sh    = (k_s2 > 11'sd49) ? 7'd74 : 7'(k_s2 + 11'sd25);
	assign ext   = {1'b0, m_s2, 25'd0};
	assign q     = ext >> sh;
	assign sig   = q[23:0];
	assign gvec  = ext >> (sh - 7'd1);
	assign g     = gvec[0];
	assign mask  = (74'd1 << (sh - 7'd1)) - 74'd1;
	assign st    = |(ext & mask);
	assign inc   = g && (st || sig[0]);
	assign sig25 = {1'b0, sig} + 25'(inc);
	assign sig_f = sig25[24] ? sig25[24:1] : sig25[23:0];
	assign be_f  = sig25[24] ? (be_s2 + 11'sd1) : be_s2;

	always_comb begin
		if (spec_s2) begin
			packed_w = spec_word_s2;
		end else if (zero_s2) begin
			packed_w = {s_s2, 31'd0};
		end else if (be_f >= 11'sd255) begin
			packed_w = {s_s2, 8'hFF, 23'd0};
		end else begin
			packed_w = {s_s2, (sig_f[23] ? be_f[7:0] : 8'h00), sig_f[22:0]};
		end
	end

	logic        v_s3;
	logic [31:0] res_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			res_s3 <= packed_w;
		end
	end

	assign done   = v_s3;
	assign result = res_s3;

endmodule

[tb/tb_sparse_dag_relu_net_evaluator.sv]
// Testbench for sparse_dag_relu_net_evaluator: loads random sparse networks, evaluates
// them, and checks every result against a binary32 predictor kept in the bench.
// Depends on sdre_pkg and the top level RTL only.
module tb_sparse_dag_relu_net_evaluator;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 40;

	typedef logic [299:0] wide_t;

	typedef struct {
		logic [sdre_pkg::WORD_W-1:0] word;
		logic [sdre_pkg::POS_W-1:0]  pos;
		logic                        st;
		logic                        lst;
	} node_result_t;

	// DUT connections
	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic [sdre_pkg::KIND_W-1:0]     kind = '0;
	logic [sdre_pkg::SLOT_W-1:0]     slot = '0;
	logic [sdre_pkg::START_W-1:0]    start_count = '0;
	logic [sdre_pkg::REF_W-1:0]      node_ref = '0;
	logic [sdre_pkg::WORD_W-1:0]     data_word = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic [sdre_pkg::WORD_W-1:0]     out_word;
	logic [sdre_pkg::POS_W-1:0]      out_position;
	logic                            status;
	logic                            last;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [sdre_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [sdre_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// predictor copy of the network memories and registers
	logic [sdre_pkg::START_W-1:0] offs_m [0:128];
	logic [31:0]                  bias_m [0:127];
	logic [sdre_pkg::REF_W-1:0]   src_m  [0:511];
	logic [31:0]                  wgt_m  [0:511];
	logic [sdre_pkg::REF_W-1:0]   omap_m [0:15];
	logic [31:0]                  nval_m [0:127];
	int unsigned                  reg_inputs = 0;
	int unsigned                  reg_total = 0;
	int unsigned                  reg_outputs = 0;

	node_result_t pending_results[$];
	int           mismatches = 0;
	int           idle_pct = 30;
	int           hold_left = 0;
	int           stall_cycles = 0;
	int           items_sent = 0;

	sparse_dag_relu_net_evaluator u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .slot(slot), .start_count(start_count), .node_ref(node_ref),
		.data_word(data_word),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_word(out_word), .out_position(out_position), .status(status), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// binary32 arithmetic, exact then rounded to nearest even
	// ---------------------------------------------------------------
	function automatic logic f32_is_nan(logic [31:0] w);
		return (w[30:23] == 8'hFF) && (w[22:0] != 0);
	endfunction

	function automatic logic f32_is_inf(logic [31:0] w);
		return (w[30:23] == 8'hFF) && (w[22:0] == 0);
	endfunction

	// value = mag * 2^ex
	function automatic void f32_unpack(logic [31:0] w, output wide_t mag, output int ex);
		mag = '0;
		if (w[30:23] == 0) begin
			mag[22:0] = w[22:0];
			ex = -149;
		end else begin
			mag[23:0] = {1'b1, w[22:0]};
			ex = int'(w[30:23]) - 150;
		end
	endfunction

	function automatic logic [31:0] f32_round(logic sgn, wide_t mag, int ex);
		int    msb;
		int    lsbe;
		int    sh;
		int    ef;
		wide_t m;
		wide_t rem;
		wide_t half;
		if (mag == 0)
			return {sgn, 31'b0};
		msb = 0;
		for (int i = 299; i >= 0; i--) begin
			if (mag[i]) begin
				msb = i;
				break;
			end
		end
		lsbe = msb + ex - 23;
		if (lsbe < -149)
			lsbe = -149;
		sh = lsbe - ex;
		if (sh <= 0) begin
			m = mag << (-sh);
		end else begin
			m = mag >> sh;
			rem = mag & ((wide_t'(1) << sh) - 1);
			half = wide_t'(1) << (sh - 1);
			if (rem > half || (rem == half && m[0]))
				m = m + 1;
		end
		if (m[24]) begin
			m = m >> 1;
			lsbe++;
		end
		ef = m[23] ? lsbe + 150 : 0;
		if (ef >= 255)
			return {sgn, 8'hFF, 23'b0};
		return {sgn, ef[7:0], m[22:0]};
	endfunction

	function automatic logic [31:0] f32_mul(logic [31:0] a, logic [31:0] b);
		wide_t ma;
		wide_t mb;
		int    ea;
		int    eb;
		logic  sgn;
		sgn = a[31] ^ b[31];
		if (f32_is_nan(a) || f32_is_nan(b))
			return sdre_pkg::FP_QNAN;
		if ((f32_is_inf(a) && b[30:0] == 0) || (f32_is_inf(b) && a[30:0] == 0))
			return sdre_pkg::FP_QNAN;
		if (f32_is_inf(a) || f32_is_inf(b))
			return {sgn, 8'hFF, 23'b0};
		f32_unpack(a, ma, ea);
		f32_unpack(b, mb, eb);
		return f32_round(sgn, ma * mb, ea + eb);
	endfunction

	function automatic logic [31:0] f32_add(logic [31:0] a, logic [31:0] b);
		wide_t ma;
		wide_t mb;
		int    ea;
		int    eb;
		int    emin;
		if (f32_is_nan(a) || f32_is_nan(b))
			return sdre_pkg::FP_QNAN;
		if (f32_is_inf(a) && f32_is_inf(b) && a[31] != b[31])
			return sdre_pkg::FP_QNAN;
		if (f32_is_inf(a))
			return a;
		if (f32_is_inf(b))
			return b;
		if (a[30:0] == 0 && b[30:0] == 0)
			return {a[31] & b[31], 31'b0};
		f32_unpack(a, ma, ea);
		f32_unpack(b, mb, eb);
		emin = (ea < eb) ? ea : eb;
		ma = ma << (ea - emin);
		mb = mb << (eb - emin);
		if (a[31] == b[31])
			return f32_round(a[31], ma + mb, emin);
		if (ma > mb)
			return f32_round(a[31], ma - mb, emin);
		if (mb > ma)
			return f32_round(b[31], mb - ma, emin);
		return sdre_pkg::FP_ZERO;
	endfunction

	// ---------------------------------------------------------------
	// network predictor
	// ---------------------------------------------------------------
	function automatic bit network_well_formed();
		int unsigned lo;
		int unsigned hi;
		if (reg_total == 0 || reg_total > sdre_pkg::MAX_NODES_DEF)
			return 0;
		if (reg_inputs > reg_total || reg_outputs == 0)
			return 0;
		if (reg_outputs > sdre_pkg::MAX_OUTPUTS_DEF || reg_outputs > sdre_pkg::RESULT_LIMIT)
			return 0;
		for (int unsigned n = 0; n < reg_total; n++) begin
			lo = offs_m[n];
			hi = offs_m[n + 1];
			if (hi < lo)
				return 0;
			if (n < reg_inputs && hi != lo)
				return 0;
			if (hi > sdre_pkg::MAX_CONN_DEF)
				return 0;
			for (int unsigned c = lo; c < hi; c++)
				if (src_m[c] >= n)
					return 0;
		end
		for (int unsigned i = 0; i < reg_outputs; i++)
			if (omap_m[i] >= reg_total)
				return 0;
		return 1;
	endfunction

	function automatic void evaluate_network();
		node_result_t r;
		logic [31:0]  acc;
		if (!network_well_formed()) begin
			r.word = '0;
			r.pos = '0;
			r.st = 1'b1;
			r.lst = 1'b1;
			pending_results.push_back(r);
			return;
		end
		for (int unsigned n = reg_inputs; n < reg_total; n++) begin
			acc = bias_m[n];
			for (int unsigned c = offs_m[n]; c < offs_m[n + 1]; c++)
				acc = f32_add(acc, f32_mul(wgt_m[c], nval_m[src_m[c]]));
			// ReLU: anything not strictly positive, NaN included, becomes +0
			if (acc[31] || acc[30:0] == 0 || f32_is_nan(acc))
				acc = sdre_pkg::FP_ZERO;
			nval_m[n] = acc;
		end
		for (int unsigned i = 0; i < reg_outputs; i++) begin
			r.word = nval_m[omap_m[i]];
			r.pos = i[sdre_pkg::POS_W-1:0];
			r.st = 1'b0;
			r.lst = (i + 1 == reg_outputs);
			pending_results.push_back(r);
		end
	endfunction

	function automatic void apply_item(logic [sdre_pkg::KIND_W-1:0] k,
			logic [sdre_pkg::SLOT_W-1:0] s, logic [sdre_pkg::START_W-1:0] sc,
			logic [sdre_pkg::REF_W-1:0] r, logic [31:0] w);
		case (k)
			sdre_pkg::KIND_OFFSET: if (s <= sdre_pkg::MAX_NODES_DEF) offs_m[s] = sc;
			sdre_pkg::KIND_BIAS:   if (s < sdre_pkg::MAX_NODES_DEF) bias_m[s] = w;
			sdre_pkg::KIND_CONN: begin
				src_m[s] = r;
				wgt_m[s] = w;
			end
			sdre_pkg::KIND_OMAP:   if (s < sdre_pkg::MAX_OUTPUTS_DEF) omap_m[s] = r;
			sdre_pkg::KIND_INPUT:  if (s < sdre_pkg::MAX_NODES_DEF) nval_m[s] = w;
			sdre_pkg::KIND_EVAL:   evaluate_network();
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------
	// drivers
	// ---------------------------------------------------------------
	task automatic send_item(logic [sdre_pkg::KIND_W-1:0] k, int unsigned s,
			int unsigned sc, int unsigned r, logic [31:0] w);
		int                           gap;
		logic [sdre_pkg::SLOT_W-1:0]  s_v;
		logic [sdre_pkg::START_W-1:0] sc_v;
		logic [sdre_pkg::REF_W-1:0]   r_v;
		s_v = s[sdre_pkg::SLOT_W-1:0];
		sc_v = sc[sdre_pkg::START_W-1:0];
		r_v = r[sdre_pkg::REF_W-1:0];
		gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 2) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		slot <= s_v;
		start_count <= sc_v;
		node_ref <= r_v;
		data_word <= w;
		do @(posedge clk); while (!in_ready);
		apply_item(k, s_v, sc_v, r_v, w);
		items_sent++;
	endtask

	task automatic send_eval();
		send_item(sdre_pkg::KIND_EVAL, $urandom_range(0, 511), $urandom_range(0, 1023),
			$urandom_range(0, 127), $urandom);
	endtask

	// one register write; the caller drops cfg_valid after the last one
	task automatic write_reg(logic [sdre_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[sdre_pkg::CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			sdre_pkg::CFG_INPUT_NODES:    reg_inputs = value & 8'hFF;
			sdre_pkg::CFG_TOTAL_NODES:    reg_total = value & 8'hFF;
			sdre_pkg::CFG_OUTPUT_ENTRIES: reg_outputs = value & 5'h1F;
			default: ;
		endcase
	endtask

	task automatic set_shape(int unsigned ni, int unsigned nt, int unsigned no);
		write_reg(sdre_pkg::CFG_INPUT_NODES, ni);
		write_reg(sdre_pkg::CFG_TOTAL_NODES, nt);
		write_reg(sdre_pkg::CFG_OUTPUT_ENTRIES, no);
		cfg_valid <= 1'b0;
	endtask

	// block idle: nothing owed, and time for any load still in flight
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// random binary32 with a bias towards ordinary magnitudes
	function automatic logic [31:0] rand_f32();
		int          pick;
		logic [31:0] w;
		pick = $urandom_range(0, 19);
		w = $urandom;
		case (pick)
			12:      w[30:0] = '0;
			13:      w[30:23] = 8'h00;
			14:      w[30:0] = {8'hFF, 23'b0};
			15:      w[30:23] = 8'hFF;
			16:      w[30:23] = 8'($urandom_range(250, 254));
			17:      ;
			default: w[30:23] = 8'($urandom_range(118, 134));
		endcase
		return w;
	endfunction

	// item that the block must ignore
	task automatic send_noise();
		case ($urandom_range(0, 4))
			0: send_item(sdre_pkg::KIND_W'($urandom_range(6, 7)), $urandom, $urandom,
				$urandom, $urandom);
			1: send_item(sdre_pkg::KIND_OFFSET, $urandom_range(129, 511), $urandom, $urandom,
				$urandom);
			2: send_item(sdre_pkg::KIND_BIAS, $urandom_range(128, 511), $urandom, $urandom,
				$urandom);
			3: send_item(sdre_pkg::KIND_OMAP, $urandom_range(16, 511), $urandom, $urandom,
				$urandom);
			default: send_item(sdre_pkg::KIND_INPUT, $urandom_range(128, 511), $urandom,
				$urandom, $urandom);
		endcase
	endtask

	task automatic maybe_noise();
		if ($urandom_range(99) < 5) begin
			send_noise();
			items_sent--;
		end
	endtask

	// random well-formed network, optionally broken just before one evaluation
	task automatic build_network(bit corrupt, int evals);
		int unsigned nt;
		int unsigned ni;
		int unsigned no;
		int unsigned cur;
		int unsigned base;
		int unsigned c;
		int unsigned n;
		int unsigned st_idx [0:10];
		nt = $urandom_range(2, 10);
		ni = $urandom_range(0, nt - 1);
		no = $urandom_range(1, 16);
		wait_idle();
		set_shape(ni, nt, no);
		base = $urandom_range(0, 470);
		cur = base;
		for (n = 0; n < nt; n++) begin
			st_idx[n] = cur;
			send_item(sdre_pkg::KIND_OFFSET, n, cur, $urandom, $urandom);
			maybe_noise();
			if (n >= ni && n > 0)
				cur += $urandom_range(0, 3);
		end
		st_idx[nt] = cur;
		send_item(sdre_pkg::KIND_OFFSET, nt, cur, $urandom, $urandom);
		for (n = ni; n < nt; n++) begin
			send_item(sdre_pkg::KIND_BIAS, n, $urandom, $urandom, rand_f32());
			for (c = st_idx[n]; c < st_idx[n + 1]; c++)
				send_item(sdre_pkg::KIND_CONN, c, $urandom, $urandom_range(0, n - 1),
					rand_f32());
			maybe_noise();
		end
		for (c = 0; c < no; c++)
			send_item(sdre_pkg::KIND_OMAP, c, $urandom, $urandom_range(0, nt - 1), $urandom);
		for (n = 0; n < ni; n++)
			send_item(sdre_pkg::KIND_INPUT, n, $urandom, $urandom, rand_f32());
		if (corrupt) begin
			case ($urandom_range(0, 2))
				0: send_item(sdre_pkg::KIND_OFFSET, nt, $urandom_range(513, 1023), $urandom,
					$urandom);
				1: begin
					if (cur > base) begin
						c = $urandom_range(base, cur - 1);
						n = ni;
						while (st_idx[n + 1] <= c) n++;
						send_item(sdre_pkg::KIND_CONN, c, $urandom, $urandom_range(n, 127),
							rand_f32());
					end else begin
						send_item(sdre_pkg::KIND_OMAP, 0, $urandom, $urandom_range(nt, 127),
							$urandom);
					end
				end
				default: send_item(sdre_pkg::KIND_OMAP, $urandom_range(0, no - 1), $urandom,
					$urandom_range(nt, 127), $urandom);
			endcase
			send_eval();
			return;
		end
		for (int e = 0; e < evals; e++) begin
			if (e > 0 && ni > 0)
				send_item(sdre_pkg::KIND_INPUT, $urandom_range(0, ni - 1), $urandom, $urandom,
					rand_f32());
			send_eval();
		end
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------
	// registers at reset leave no nodes, so the first evaluation is an error
	task automatic test_reset_state();
		send_eval();
		wait_idle();
	endtask

	// register extremes that are caught before any table is read
	task automatic test_register_limits();
		set_shape(0, 255, 1);
		send_eval();
		wait_idle();
		set_shape(200, 128, 16);
		send_eval();
		wait_idle();
		set_shape(128, 128, 0);
		send_eval();
		wait_idle();
		set_shape(0, 5, 31);
		send_eval();
		wait_idle();
		set_shape(0, 5, 17);
		send_eval();
		wait_idle();
	endtask

	// hand-built net: inf times zero, negative sums, input values kept across runs
	task automatic test_directed_network();
		set_shape(2, 4, 4);
		send_item(sdre_pkg::KIND_OFFSET, 0, 0, 0, 0);
		send_item(sdre_pkg::KIND_OFFSET, 1, 0, 0, 0);
		send_item(sdre_pkg::KIND_OFFSET, 2, 0, 0, 0);
		send_item(sdre_pkg::KIND_OFFSET, 3, 2, 0, 0);
		send_item(sdre_pkg::KIND_OFFSET, 4, 4, 0, 0);
		send_item(sdre_pkg::KIND_BIAS, 2, 0, 0, 32'h3F80_0000);
		send_item(sdre_pkg::KIND_BIAS, 3, 0, 0, 32'h3F80_0000);
		send_item(sdre_pkg::KIND_CONN, 0, 0, 0, 32'h7F80_0000);
		send_item(sdre_pkg::KIND_CONN, 1, 0, 1, 32'h3F80_0000);
		send_item(sdre_pkg::KIND_CONN, 2, 0, 2, 32'hBF80_0000);
		send_item(sdre_pkg::KIND_CONN, 3, 0, 1, 32'h3F00_0000);
		for (int unsigned i = 0; i < 4; i++)
			send_item(sdre_pkg::KIND_OMAP, i, 0, 3 - i, 0);
		send_item(sdre_pkg::KIND_INPUT, 0, 0, 0, sdre_pkg::FP_ZERO);
		send_item(sdre_pkg::KIND_INPUT, 1, 0, 0, 32'h4000_0000);
		send_eval();
		send_item(sdre_pkg::KIND_INPUT, 0, 0, 0, 32'h3F80_0000);
		send_eval();
		send_item(sdre_pkg::KIND_BIAS, 3, 0, 0, 32'h7F7F_FFFF);
		send_item(sdre_pkg::KIND_CONN, 511, 1023, 127, 32'hFFFF_FFFF);
		send_eval();
		wait_idle();
	endtask

	// each malformation of the hand-built net, restored afterwards
	task automatic test_malformed();
		// offsets decreasing
		send_item(sdre_pkg::KIND_OFFSET, 4, 1, 0, 0);
		send_eval();
		send_item(sdre_pkg::KIND_OFFSET, 4, 4, 0, 0);
		// connection into an input node
		send_item(sdre_pkg::KIND_OFFSET, 2, 1, 0, 0);
		send_eval();
		send_item(sdre_pkg::KIND_OFFSET, 2, 0, 0, 0);
		// source not below its node
		send_item(sdre_pkg::KIND_CONN, 1, 0, 2, 32'h3F80_0000);
		send_eval();
		send_item(sdre_pkg::KIND_CONN, 1, 0, 1, 32'h3F80_0000);
		// output map beyond the nodes
		send_item(sdre_pkg::KIND_OMAP, 0, 0, 4, 0);
		send_eval();
		send_item(sdre_pkg::KIND_OMAP, 0, 0, 3, 0);
		// connection index beyond the table
		send_item(sdre_pkg::KIND_OFFSET, 4, 600, 0, 0);
		send_eval();
		send_item(sdre_pkg::KIND_OFFSET, 4, 512, 0, 0);
		send_item(sdre_pkg::KIND_OFFSET, 4, 4, 0, 0);
		send_eval();
		wait_idle();
	endtask

	task automatic test_random_networks();
		while (items_sent < 170)
			build_network($urandom_range(99) < 15, $urandom_range(1, 3));
	endtask

	task automatic test_no_idle();
		idle_pct = 0;
		build_network(0, 2);
		build_network(0, 2);
		wait_idle();
		idle_pct = 30;
	endtask

	// receiver holds off while the sender keeps offering evaluations
	task automatic test_output_stall();
		wait_idle();
		hold_left = 400;
		build_network(0, 3);
		wait_idle();
	endtask

	// ---------------------------------------------------------------
	// receiver and result check
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	always @(posedge clk) begin
		node_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result word=%h pos=%0d status=%0d last=%0d",
						out_word, out_position, status, last);
				mismatches++;
			end else begin
				exp_r = pending_results.pop_front();
				if (out_word !== exp_r.word || out_position !== exp_r.pos ||
						status !== exp_r.st || last !== exp_r.lst) begin
					if (mismatches < 10)
						$display("mismatch: expected %h/%0d/%0d/%0d got %h/%0d/%0d/%0d",
							exp_r.word, exp_r.pos, exp_r.st, exp_r.lst,
							out_word, out_position, status, last);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles with no item moving anywhere
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_register_limits();
		test_directed_network();
		test_malformed();
		test_random_networks();
		test_no_idle();
		test_output_stall();
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[files.f]
src/sdre_pkg.sv
src/sdre_ram.sv
src/sdre_fpu.sv
src/sparse_dag_relu_net_evaluator.sv
tb/tb_sparse_dag_relu_net_evaluator.sv
